@@ design/buq_pkg.sv @@
// shared types and constants for the buffered uart queue block
// no dependencies; imported by buq_front, buq_back and the top level
`default_nettype none

package buq_pkg;

   localparam int BYTE_W   = 8;
   localparam int CNT_W    = 7;
   localparam logic [CNT_W-1:0] MAX_READ = 7'd64;
   localparam logic [CNT_W-1:0] SAT_MAX  = 7'd127;

   typedef enum logic [1:0] {
      OP_TX_BYTE   = 2'd0,
      OP_TX_EMPTY  = 2'd1,
      OP_RX_BYTE   = 2'd2,
      OP_HOST_READ = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_TX_REJECT = 2'd1,
      STATUS_RX_EMPTY  = 2'd2,
      STATUS_RX_DROP   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_EXEC = 2'd1,
      ST_READ = 2'd2
   } state_type;

   typedef struct packed {
      op_type              op;
      logic [BYTE_W-1:0]   data_byte;
      logic [CNT_W-1:0]    count;
      logic                burst_first;
      logic                line_ready;
   } item_type;

endpackage

`default_nettype wire

@@ design/buffered_uart_tx_rx_queues_unit.sv @@
// Buffered UART transmit/receive queue unit. The front end takes one request
// transaction per cycle, while req_stall is low, into a two-entry queue; the
// back end then fetches each transaction and presents the queue heads from
// the registered memory read ports, then executes it into the response
// register, and a host read returns its bytes one byte per cycle out of the
// receive memory while rsp_stall does not hold the response. While a response
// waits on rsp_stall the back end holds its next transaction in the execute
// step, so a stall delays that transaction. Queue memories need no clearing
// after reset. Depends on buq_pkg, buq_front and buq_back.
`default_nettype none

module buffered_uart_tx_rx_queues_unit #(
   parameter int TX_DEPTH = 64,
   parameter int RX_DEPTH = 64
) (
   input  wire         clock,
   input  wire         reset,
   // request channel
   input  wire         req_valid,
   output logic        req_stall,
   input  wire  [1:0]  req_action,
   input  wire  [7:0]  req_data_byte,
   input  wire  [6:0]  req_count,
   input  wire         req_burst_first,
   input  wire         req_line_ready,
   // response channel
   output logic        rsp_valid,
   input  wire         rsp_stall,
   output logic [1:0]  rsp_status,
   output logic        rsp_line_write,
   output logic [7:0]  rsp_line_byte,
   output logic        rsp_rx_valid,
   output logic [7:0]  rsp_rx_byte,
   output logic        rsp_last,
   output logic        rsp_tx_busy,
   output logic        rsp_tx_irq_enable,
   output logic [6:0]  rsp_rx_level,
   output logic [6:0]  rsp_tx_free
);
   import buq_pkg::*;

   // handoff between front and back
   logic     item_valid;
   item_type item;
   logic     item_pop;

   // front: decode, clamp read lengths, buffer transactions
   buq_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_action      (req_action),
      .req_data_byte   (req_data_byte),
      .req_count       (req_count),
      .req_burst_first (req_burst_first),
      .req_line_ready  (req_line_ready),
      .item_valid      (item_valid),
      .item            (item),
      .item_pop        (item_pop)
   );

   // back: ring queues, burst admission, transmitter kick-start, host reads
   buq_back #(
      .TX_DEPTH (TX_DEPTH),
      .RX_DEPTH (RX_DEPTH)
   ) u_back (
      .clock             (clock),
      .reset             (reset),
      .item_valid        (item_valid),
      .item              (item),
      .item_pop          (item_pop),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_line_write    (rsp_line_write),
      .rsp_line_byte     (rsp_line_byte),
      .rsp_rx_valid      (rsp_rx_valid),
      .rsp_rx_byte       (rsp_rx_byte),
      .rsp_last          (rsp_last),
      .rsp_tx_busy       (rsp_tx_busy),
      .rsp_tx_irq_enable (rsp_tx_irq_enable),
      .rsp_rx_level      (rsp_rx_level),
      .rsp_tx_free       (rsp_tx_free)
   );

endmodule

`default_nettype wire

@@ design/buq_front.sv @@
// front end: takes request transactions, classifies them, holds them in a two-entry queue
// depends on buq_pkg
`default_nettype none

module buq_front (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_valid,
   output logic                      req_stall,
   input  wire  [1:0]                req_action,
   input  wire  [7:0]                req_data_byte,
   input  wire  [6:0]                req_count,
   input  wire                       req_burst_first,
   input  wire                       req_line_ready,
   output logic                      item_valid,
   output buq_pkg::item_type         item,
   input  wire                       item_pop
);
   import buq_pkg::*;

   item_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] fill_ff, fill_in;
   logic       push;
   item_type   decoded;

   // classify the transaction and clamp read lengths
   always_comb begin
      decoded.data_byte   = req_data_byte;
      decoded.burst_first = req_burst_first;
      decoded.line_ready  = req_line_ready;
      decoded.count       = req_count;
      unique case (op_type'(req_action))
         OP_TX_BYTE:  decoded.op = OP_TX_BYTE;
         OP_TX_EMPTY: decoded.op = OP_TX_EMPTY;
         OP_RX_BYTE:  decoded.op = OP_RX_BYTE;
         OP_HOST_READ: begin
            decoded.op = OP_HOST_READ;
            if (req_count > MAX_READ) begin
               decoded.count = MAX_READ;
            end
         end
         default: decoded.op = OP_TX_BYTE;
      endcase
   end

   assign req_stall  = (fill_ff == 2'd2);
   assign push       = req_valid && !req_stall;
   assign item_valid = (fill_ff != 2'd0);
   assign item       = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = item_pop ? !rd_ptr_ff : rd_ptr_ff;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, item_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

`default_nettype wire

@@ design/buq_back.sv @@
// back end: transmit and receive ring queues, burst admission, kick-start and result register
// depends on buq_pkg
`default_nettype none

module buq_back #(
   parameter int TX_DEPTH = 64,
   parameter int RX_DEPTH = 64
) (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       item_valid,
   input  buq_pkg::item_type         item,
   output logic                      item_pop,
   output logic                      rsp_valid,
   input  wire                       rsp_stall,
   output logic [1:0]                rsp_status,
   output logic                      rsp_line_write,
   output logic [7:0]                rsp_line_byte,
   output logic                      rsp_rx_valid,
   output logic [7:0]                rsp_rx_byte,
   output logic                      rsp_last,
   output logic                      rsp_tx_busy,
   output logic                      rsp_tx_irq_enable,
   output logic [6:0]                rsp_rx_level,
   output logic [6:0]                rsp_tx_free
);
   import buq_pkg::*;

   localparam int TX_AW = $clog2(TX_DEPTH);
   localparam int RX_AW = $clog2(RX_DEPTH);
   localparam int TX_LW = $clog2(TX_DEPTH + 1);
   localparam int RX_LW = $clog2(RX_DEPTH + 1);
   localparam int TXC   = (TX_LW > CNT_W) ? TX_LW : CNT_W;
   localparam int RXC   = (RX_LW > CNT_W) ? RX_LW : CNT_W;
   localparam logic [TX_AW-1:0] TX_LAST = TX_AW'(TX_DEPTH - 1);
   localparam logic [RX_AW-1:0] RX_LAST = RX_AW'(RX_DEPTH - 1);
   localparam logic [TX_LW-1:0] TX_FULL = TX_LW'(TX_DEPTH);
   localparam logic [RX_LW-1:0] RX_FULL = RX_LW'(RX_DEPTH);

   // storage
   logic [BYTE_W-1:0] tx_store_ff [TX_DEPTH];
   logic [BYTE_W-1:0] rx_store_ff [RX_DEPTH];
   logic [BYTE_W-1:0] tx_rdata_ff, rx_rdata_ff;

   state_type         state_ff, state_in;
   item_type          item_ff, item_in;
   logic [CNT_W-1:0]  read_left_ff, read_left_in;
   logic [TX_AW-1:0]  tx_head_ff, tx_head_in, tx_tail_ff, tx_tail_in;
   logic [TX_LW-1:0]  tx_level_ff, tx_level_in;
   logic [RX_AW-1:0]  rx_head_ff, rx_head_in, rx_tail_ff, rx_tail_in;
   logic [RX_LW-1:0]  rx_fill_ff, rx_fill_in;
   logic              busy_ff, busy_in, irq_ff, irq_in;
   logic [CNT_W-1:0]  burst_left_ff, burst_left_in;
   logic              refused_ff, refused_in;

   logic              tx_we, rx_we, out_free, load, wrote;
   logic [TX_LW-1:0]  tx_level_mid;
   logic [TXC-1:0]    tx_free_x, tx_free_out;
   logic [RXC-1:0]    rx_fill_x, n_eff;
   status_type        r_status;
   logic              r_lw, r_rv, r_last;
   logic [BYTE_W-1:0] r_lb, r_rb;

   logic              rsp_valid_ff;
   status_type        status_ff;
   logic              line_write_ff, rx_valid_ff, last_ff, tx_busy_ff, tx_irq_ff;
   logic [BYTE_W-1:0] line_byte_ff, rx_byte_ff;
   logic [CNT_W-1:0]  rx_level_ff, tx_free_ff;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign tx_free_x = TXC'(TX_DEPTH) - TXC'(tx_level_ff);
   assign rx_fill_x = RXC'(rx_fill_ff);

   always_comb begin
      state_in      = state_ff;
      item_in       = item_ff;
      read_left_in  = read_left_ff;
      tx_head_in    = tx_head_ff;
      tx_tail_in    = tx_tail_ff;
      tx_level_in   = tx_level_ff;
      rx_head_in    = rx_head_ff;
      rx_tail_in    = rx_tail_ff;
      rx_fill_in    = rx_fill_ff;
      busy_in       = busy_ff;
      irq_in        = irq_ff;
      burst_left_in = burst_left_ff;
      refused_in    = refused_ff;
      tx_we         = 1'b0;
      rx_we         = 1'b0;
      item_pop      = 1'b0;
      load          = 1'b0;
      wrote         = 1'b0;
      tx_level_mid  = tx_level_ff;
      n_eff         = '0;
      r_status      = STATUS_OK;
      r_lw          = 1'b0;
      r_lb          = '0;
      r_rv          = 1'b0;
      r_rb          = '0;
      r_last        = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (item_valid) begin
               item_pop = 1'b1;
               item_in  = item;
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            if (out_free) begin
               load     = 1'b1;
               state_in = ST_IDLE;
               unique case (item_ff.op)
                  OP_TX_BYTE: begin
                     if (item_ff.burst_first && item_ff.count == '0) begin
                        // zero-length burst closes any open burst
                        burst_left_in = '0;
                        refused_in    = 1'b0;
                     end else begin
                        if (item_ff.burst_first) begin
                           burst_left_in = item_ff.count;
                           refused_in    = tx_free_x < TXC'(item_ff.count);
                        end else if (burst_left_ff == '0) begin
                           // stray byte: burst of one
                           burst_left_in = CNT_W'(1);
                           refused_in    = (tx_level_ff == TX_FULL);
                        end
                        if (refused_in || tx_level_ff == TX_FULL) begin
                           r_status = STATUS_TX_REJECT;
                        end else begin
                           tx_we        = 1'b1;
                           wrote        = 1'b1;
                           tx_tail_in   = (tx_tail_ff == TX_LAST) ? '0 : tx_tail_ff + 1'b1;
                           tx_level_mid = tx_level_ff + 1'b1;
                        end
                        tx_level_in   = tx_level_mid;
                        burst_left_in = burst_left_in - 1'b1;
                        // kick-start after the last byte of an accepted burst
                        if (burst_left_in == '0 && !refused_in) begin
                           if (busy_ff) begin
                              irq_in = 1'b1;
                           end else begin
                              busy_in = 1'b1;
                              if (item_ff.line_ready) begin
                                 if (tx_level_mid != '0) begin
                                    r_lw        = 1'b1;
                                    // an empty queue means the head is the byte just written
                                    r_lb        = (wrote && tx_level_ff == '0) ?
                                                  item_ff.data_byte : tx_rdata_ff;
                                    tx_head_in  = (tx_head_ff == TX_LAST) ?
                                                  '0 : tx_head_ff + 1'b1;
                                    tx_level_in = tx_level_mid - 1'b1;
                                    irq_in      = 1'b1;
                                 end else begin
                                    busy_in = 1'b0;
                                    irq_in  = 1'b0;
                                 end
                              end else begin
                                 irq_in = 1'b1;
                              end
                           end
                        end
                        if (burst_left_in == '0) begin
                           refused_in = 1'b0;
                        end
                     end
                  end

                  OP_TX_EMPTY: begin
                     if (busy_ff && irq_ff) begin
                        if (tx_level_ff != '0) begin
                           r_lw        = 1'b1;
                           r_lb        = tx_rdata_ff;
                           tx_head_in  = (tx_head_ff == TX_LAST) ? '0 : tx_head_ff + 1'b1;
                           tx_level_in = tx_level_ff - 1'b1;
                        end else begin
                           busy_in = 1'b0;
                           irq_in  = 1'b0;
                        end
                     end
                  end

                  OP_RX_BYTE: begin
                     if (rx_fill_ff != RX_FULL) begin
                        rx_we      = 1'b1;
                        rx_tail_in = (rx_tail_ff == RX_LAST) ? '0 : rx_tail_ff + 1'b1;
                        rx_fill_in = rx_fill_ff + 1'b1;
                     end else begin
                        r_status = STATUS_RX_DROP;
                     end
                  end

                  OP_HOST_READ: begin
                     if (item_ff.count == '0) begin
                        r_status = STATUS_OK;
                     end else if (rx_fill_ff == '0) begin
                        r_status = STATUS_RX_EMPTY;
                     end else begin
                        n_eff      = (RXC'(item_ff.count) > rx_fill_x) ?
                                     rx_fill_x : RXC'(item_ff.count);
                        r_rv       = 1'b1;
                        r_rb       = rx_rdata_ff;
                        rx_head_in = (rx_head_ff == RX_LAST) ? '0 : rx_head_ff + 1'b1;
                        rx_fill_in = rx_fill_ff - 1'b1;
                        r_last     = (n_eff == RXC'(1));
                        if (!r_last) begin
                           read_left_in = n_eff[CNT_W-1:0] - 1'b1;
                           state_in     = ST_READ;
                        end
                     end
                  end

                  default: r_status = STATUS_OK;
               endcase
            end
         end

         ST_READ: begin
            // one byte per cycle while out_free holds; read data follows the head pointer
            if (out_free) begin
               load         = 1'b1;
               r_rv         = 1'b1;
               r_rb         = rx_rdata_ff;
               rx_head_in   = (rx_head_ff == RX_LAST) ? '0 : rx_head_ff + 1'b1;
               rx_fill_in   = rx_fill_ff - 1'b1;
               r_last       = (read_left_ff == CNT_W'(1));
               read_left_in = read_left_ff - 1'b1;
               if (r_last) begin
                  state_in = ST_IDLE;
               end
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   assign tx_free_out = TXC'(TX_DEPTH) - TXC'(tx_level_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         read_left_ff  <= '0;
         tx_head_ff    <= '0;
         tx_tail_ff    <= '0;
         tx_level_ff   <= '0;
         rx_head_ff    <= '0;
         rx_tail_ff    <= '0;
         rx_fill_ff    <= '0;
         busy_ff       <= 1'b0;
         irq_ff        <= 1'b0;
         burst_left_ff <= '0;
         refused_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         read_left_ff  <= read_left_in;
         tx_head_ff    <= tx_head_in;
         tx_tail_ff    <= tx_tail_in;
         tx_level_ff   <= tx_level_in;
         rx_head_ff    <= rx_head_in;
         rx_tail_ff    <= rx_tail_in;
         rx_fill_ff    <= rx_fill_in;
         busy_ff       <= busy_in;
         irq_ff        <= irq_in;
         burst_left_ff <= burst_left_in;
         refused_ff    <= refused_in;
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      item_ff <= item_in;
      if (load) begin
         status_ff     <= r_status;
         line_write_ff <= r_lw;
         line_byte_ff  <= r_lb;
         rx_valid_ff   <= r_rv;
         rx_byte_ff    <= r_rb;
         last_ff       <= r_last;
         tx_busy_ff    <= busy_in;
         tx_irq_ff     <= irq_in;
         rx_level_ff   <= (RXC'(rx_fill_in) > RXC'(SAT_MAX)) ?
                          SAT_MAX : CNT_W'(RXC'(rx_fill_in));
         tx_free_ff    <= (tx_free_out > TXC'(SAT_MAX)) ? SAT_MAX : CNT_W'(tx_free_out);
      end
   end

   // queue memories, registered read at the next head position
   always_ff @(posedge clock) begin
      if (tx_we) begin
         tx_store_ff[tx_tail_ff] <= item_ff.data_byte;
      end
      tx_rdata_ff <= tx_store_ff[tx_head_in];
   end

   always_ff @(posedge clock) begin
      if (rx_we) begin
         rx_store_ff[rx_tail_ff] <= item_ff.data_byte;
      end
      rx_rdata_ff <= rx_store_ff[rx_head_in];
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_line_write    = line_write_ff;
   assign rsp_line_byte     = line_byte_ff;
   assign rsp_rx_valid      = rx_valid_ff;
   assign rsp_rx_byte       = rx_byte_ff;
   assign rsp_last          = last_ff;
   assign rsp_tx_busy       = tx_busy_ff;
   assign rsp_tx_irq_enable = tx_irq_ff;
   assign rsp_rx_level      = rx_level_ff;
   assign rsp_tx_free       = tx_free_ff;

`ifndef SYNTHESIS
   a_tx_level_bound: assert property (@(posedge clock) disable iff (reset)
      tx_level_ff <= TX_FULL)
      else $error("transmit level above depth");
   a_rx_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rx_fill_ff <= RX_FULL)
      else $error("receive fill above depth");
   a_irq_needs_busy: assert property (@(posedge clock) disable iff (reset)
      irq_ff |-> busy_ff)
      else $error("interrupt enable set while transmitter idle");
   a_read_has_bytes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ) |-> (read_left_ff != '0 && rx_fill_ff >= RX_LW'(read_left_ff)))
      else $error("read burst longer than receive fill");
`endif

endmodule

`default_nettype wire
